// ===== rtl/wsdm_pkg.sv =====
// wsdm_pkg: widths, register codes, reset values and shared types of the
// wheel speed and distance meter. No dependencies.
`default_nettype none

package wsdm_pkg;

   localparam int TIME_BITS_DEF = 32;
   localparam int TIMESTAMP_W = 32;
   localparam int CIRC_W = 16;
   localparam int LIMIT_W = 10;
   localparam int IDLE_W = 16;
   localparam int SPEED_W = 26;
   localparam int DIST_W = 48;
   localparam int SUM_W = 40;
   localparam int REV_W = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int MS_W = 10;
   localparam int TERM_W = CIRC_W + MS_W;
   localparam int IDLE_INTERVAL_W = 28;
   localparam int DIV_STEP_W = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_WHEEL_CIRC = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT = 2'd2;

   localparam logic [CIRC_W-1:0] CIRC_RESET = 16'd2255;
   localparam logic [LIMIT_W-1:0] AVERAGE_RESET = 10'd100;
   localparam logic [IDLE_W-1:0] IDLE_RESET = 16'd4000;
   localparam logic [IDLE_INTERVAL_W-1:0] IDLE_INTERVAL = 28'd160000000;
   localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;

   localparam logic [DIV_STEP_W-1:0] TERM_STEPS = DIV_STEP_W'(TERM_W);
   localparam logic [DIV_STEP_W-1:0] AVERAGE_STEPS = DIV_STEP_W'(SUM_W);

   typedef struct packed {
      logic [CIRC_W-1:0] wheel_circ_mm;
      logic [LIMIT_W-1:0] average_limit;
      logic [IDLE_W-1:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [TIMESTAMP_W-1:0] time_ms;
      logic sensor_level;
      logic clear_session;
   } poll_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_mm_s;
      logic [DIST_W-1:0] distance_mm;
      logic speed_updated;
      logic rev_seen;
   } result_type;

   typedef struct packed {
      logic start;
      logic [DIV_STEP_W-1:0] steps;
      logic [SUM_W-1:0] dividend;
   } div_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/wsdm_req_if.sv =====
// wsdm_req_if: request channel of the meter, one sensor poll per request.
// Depends on wsdm_pkg.
`default_nettype none

interface wsdm_req_if;
   logic valid;
   logic ready;
   logic [wsdm_pkg::TIMESTAMP_W-1:0] time_ms;
   logic sensor_level;
   logic clear_session;

   modport source (output valid, output time_ms, output sensor_level,
                   output clear_session, input ready);
   modport sink (input valid, input time_ms, input sensor_level,
                 input clear_session, output ready);
endinterface

`default_nettype wire

// ===== rtl/wsdm_rsp_if.sv =====
// wsdm_rsp_if: response channel of the meter, one result per poll.
// Depends on wsdm_pkg.
`default_nettype none

interface wsdm_rsp_if;
   logic valid;
   logic ready;
   logic [wsdm_pkg::SPEED_W-1:0] speed_mm_s;
   logic [wsdm_pkg::DIST_W-1:0] distance_mm;
   logic speed_updated;
   logic rev_seen;

   modport source (output valid, output speed_mm_s, output distance_mm,
                   output speed_updated, output rev_seen, input ready);
   modport sink (input valid, input speed_mm_s, input distance_mm,
                 input speed_updated, input rev_seen, output ready);
endinterface

`default_nettype wire

// ===== rtl/wheel_speed_distance_meter.sv =====
// Wheel speed and distance meter, top level: configuration registers,
// response register, sequencer and shared divider.
// Depends on wsdm_pkg, wsdm_req_if, wsdm_rsp_if, wsdm_seq, wsdm_div.
//
// usage
//   req carries one sensor poll (time_ms, sensor_level, clear_session);
//   rsp returns one result per poll (speed_mm_s, distance_mm,
//   speed_updated, rev_seen). csr_* writes wheel circumference, average
//   limit and idle limit by index; write only while no poll is in flight.
// timing
//   a poll runs the per-poll term division, and also the window average
//   division when it closes an averaging window; req.ready returns the
//   cycle before rsp valid, so a new poll is taken only after the last one
//   leaves the sequencer. The shared restoring divider gives one quotient
//   bit per cycle: 26 bits for the per-poll term, 40 for the window average.
// reset
//   synchronous; registers return to their defaults, counters, sum and
//   speed clear, interval takes the idle value, sensor level taken as high.
// stalls
//   a result waits in the response register while rsp.ready is low; a
//   following poll is taken and computed, then held until the register frees.
`default_nettype none

module wheel_speed_distance_meter #(
   parameter int TIME_BITS = wsdm_pkg::TIME_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   wsdm_req_if.sink                               req,
   wsdm_rsp_if.source                             rsp,
   input  wire logic                              csr_write_en,
   input  wire logic [wsdm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [wsdm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IW = (TIME_BITS > wsdm_pkg::IDLE_INTERVAL_W) ?
                       TIME_BITS : wsdm_pkg::IDLE_INTERVAL_W;

   wsdm_pkg::cfg_type cfg_ff, cfg_in;
   wsdm_pkg::result_type rsp_data_ff, rsp_data_in;
   logic rsp_valid_ff, rsp_valid_in;

   wsdm_pkg::poll_type poll;
   wsdm_pkg::div_cmd_type div_cmd;
   wsdm_pkg::result_type res;
   logic [IW-1:0] div_divisor;
   logic [wsdm_pkg::SUM_W-1:0] div_quot;
   logic div_done;
   logic res_valid;
   logic out_free;
   logic poll_ready;

   assign poll.time_ms = req.time_ms;
   assign poll.sensor_level = req.sensor_level;
   assign poll.clear_session = req.clear_session;
   assign req.ready = poll_ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            wsdm_pkg::CSR_WHEEL_CIRC: begin
               cfg_in.wheel_circ_mm = csr_wdata[wsdm_pkg::CIRC_W-1:0];
            end
            wsdm_pkg::CSR_AVERAGE_LIMIT: begin
               cfg_in.average_limit = csr_wdata[wsdm_pkg::LIMIT_W-1:0];
            end
            wsdm_pkg::CSR_IDLE_LIMIT: begin
               cfg_in.idle_limit = csr_wdata[wsdm_pkg::IDLE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_data_in = res;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_circ_mm <= wsdm_pkg::CIRC_RESET;
         cfg_ff.average_limit <= wsdm_pkg::AVERAGE_RESET;
         cfg_ff.idle_limit <= wsdm_pkg::IDLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.speed_mm_s = rsp_data_ff.speed_mm_s;
   assign rsp.distance_mm = rsp_data_ff.distance_mm;
   assign rsp.speed_updated = rsp_data_ff.speed_updated;
   assign rsp.rev_seen = rsp_data_ff.rev_seen;

   wsdm_seq #(
      .TIME_BITS (TIME_BITS),
      .IW        (IW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .poll        (poll),
      .poll_valid  (req.valid),
      .poll_ready  (poll_ready),
      .div_cmd     (div_cmd),
      .div_divisor (div_divisor),
      .div_done    (div_done),
      .div_quot    (div_quot),
      .out_free    (out_free),
      .res         (res),
      .res_valid   (res_valid)
   );

   wsdm_div #(
      .DVSR_W (IW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

endmodule

`default_nettype wire

// ===== rtl/wsdm_div.sv =====
// wsdm_div: shared restoring divider, one quotient bit per cycle.
// Dividend is taken msb first for a given number of steps. Depends on wsdm_pkg.
`default_nettype none

module wsdm_div #(
   parameter int DVSR_W = wsdm_pkg::IDLE_INTERVAL_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire wsdm_pkg::div_cmd_type        cmd,
   input  wire logic [DVSR_W-1:0]            divisor,
   output logic                              done,
   output logic [wsdm_pkg::SUM_W-1:0]        quotient
);

   localparam int SW = wsdm_pkg::SUM_W;

   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvsr_ff, dvsr_in;
   logic [SW-1:0] dend_ff, dend_in;
   logic [SW-1:0] quot_ff, quot_in;
   logic [wsdm_pkg::DIV_STEP_W-1:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   logic [DVSR_W:0] rem_shift;
   logic [DVSR_W:0] rem_diff;
   logic fits;

   assign rem_shift = {rem_ff, dend_ff[SW-1]};
   assign fits = rem_shift >= {1'b0, dvsr_ff};
   assign rem_diff = rem_shift - {1'b0, dvsr_ff};

   always_comb begin
      rem_in = rem_ff;
      dvsr_in = dvsr_ff;
      dend_in = dend_ff;
      quot_in = quot_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         rem_in = '0;
         dvsr_in = divisor;
         dend_in = cmd.dividend;
         quot_in = '0;
         count_in = cmd.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[DVSR_W-1:0] : rem_shift[DVSR_W-1:0];
         dend_in = {dend_ff[SW-2:0], 1'b0};
         quot_in = {quot_ff[SW-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == wsdm_pkg::DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dvsr_ff <= dvsr_in;
      dend_ff <= dend_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quotient = quot_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider finished without running");

endmodule

`default_nettype wire

// ===== rtl/wsdm_seq.sv =====
// wsdm_seq: poll sequencer and running state (edge, counters, sum, speed).
// Drives the shared divider for the per-poll term and the window average.
// Depends on wsdm_pkg.
`default_nettype none

module wsdm_seq #(
   parameter int TIME_BITS = wsdm_pkg::TIME_BITS_DEF,
   parameter int IW = wsdm_pkg::IDLE_INTERVAL_W
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire wsdm_pkg::cfg_type           cfg,
   input  wire wsdm_pkg::poll_type          poll,
   input  wire logic                        poll_valid,
   output logic                             poll_ready,
   output wsdm_pkg::div_cmd_type            div_cmd,
   output logic [IW-1:0]                    div_divisor,
   input  wire logic                        div_done,
   input  wire logic [wsdm_pkg::SUM_W-1:0]  div_quot,
   input  wire logic                        out_free,
   output wsdm_pkg::result_type             res,
   output logic                             res_valid
);

   localparam int SW = wsdm_pkg::SUM_W;
   localparam int SPW = wsdm_pkg::SPEED_W;
   localparam int TW = wsdm_pkg::TERM_W;
   localparam int DW = wsdm_pkg::DIST_W;
   localparam int LW = wsdm_pkg::LIMIT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE,
      S_TERM_LOAD,
      S_TERM_RUN,
      S_SUM,
      S_AVG_RUN,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   wsdm_pkg::poll_type poll_ff, poll_in;
   logic prev_level_ff, prev_level_in;
   logic [wsdm_pkg::REV_W-1:0] rev_count_ff, rev_count_in;
   logic [TIME_BITS-1:0] last_edge_ff, last_edge_in;
   logic [IW-1:0] interval_ff, interval_in;
   logic [wsdm_pkg::IDLE_W-1:0] idle_ff, idle_in;
   logic [LW-1:0] window_ff, window_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [SPW-1:0] held_ff, held_in;
   logic rev_seen_ff, rev_seen_in;
   logic updated_ff, updated_in;
   logic [DW-1:0] distance_ff, distance_in;
   wsdm_pkg::div_cmd_type div_cmd_ff, div_cmd_in;
   logic [IW-1:0] divisor_ff, divisor_in;
   wsdm_pkg::result_type res_ff, res_in;
   logic res_valid_ff, res_valid_in;

   logic [TIME_BITS-1:0] now;
   logic fell;
   logic [SW:0] sum_add;
   logic [SW-1:0] sum_sat;
   logic [wsdm_pkg::IDLE_W-1:0] idle_inc;
   logic window_match;
   logic [TW-1:0] term_dividend;

   assign now = TIME_BITS'(poll_ff.time_ms);
   assign fell = prev_level_ff & ~poll_ff.sensor_level;
   assign sum_add = {1'b0, sum_ff} + (SW + 1)'(div_quot[TW-1:0]);
   assign sum_sat = sum_add[SW] ? '1 : sum_add[SW-1:0];
   assign idle_inc = idle_ff + 1'b1;
   assign window_match = window_ff == cfg.average_limit;
   assign term_dividend = TW'(cfg.wheel_circ_mm) * TW'(wsdm_pkg::MS_PER_S);

   always_comb begin
      state_in = state_ff;
      poll_in = poll_ff;
      prev_level_in = prev_level_ff;
      rev_count_in = rev_count_ff;
      last_edge_in = last_edge_ff;
      interval_in = interval_ff;
      idle_in = idle_ff;
      window_in = window_ff;
      sum_in = sum_ff;
      held_in = held_ff;
      rev_seen_in = rev_seen_ff;
      updated_in = updated_ff;
      distance_in = distance_ff;
      div_cmd_in = div_cmd_ff;
      div_cmd_in.start = 1'b0;
      divisor_in = divisor_ff;
      res_in = res_ff;
      res_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (poll_valid) begin
               poll_in = poll;
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            if (poll_ff.clear_session) begin
               rev_count_in = '0;
               last_edge_in = '0;
               interval_in = IW'(wsdm_pkg::IDLE_INTERVAL);
               idle_in = '0;
               window_in = '0;
               sum_in = '0;
               held_in = '0;
            end
            if (fell) begin
               idle_in = '0;
               rev_count_in = (poll_ff.clear_session ? '0 : rev_count_ff) + 1'b1;
               interval_in = IW'(now - (poll_ff.clear_session ? '0 : last_edge_ff));
               last_edge_in = now;
            end
            rev_seen_in = fell;
            updated_in = 1'b0;
            prev_level_in = poll_ff.sensor_level;
            state_in = S_TERM_LOAD;
         end
         S_TERM_LOAD: begin
            div_cmd_in.start = 1'b1;
            div_cmd_in.steps = wsdm_pkg::TERM_STEPS;
            div_cmd_in.dividend = {term_dividend, (SW - TW)'(0)};
            divisor_in = (interval_ff == '0) ? IW'(1) : interval_ff;
            distance_in = DW'(rev_count_ff) * DW'(cfg.wheel_circ_mm);
            state_in = S_TERM_RUN;
         end
         S_TERM_RUN: begin
            if (div_done) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (idle_inc == cfg.idle_limit) begin
               interval_in = IW'(wsdm_pkg::IDLE_INTERVAL);
               idle_in = '0;
            end else begin
               idle_in = idle_inc;
            end
            if (window_match) begin
               window_in = LW'(1);
               sum_in = '0;
               updated_in = 1'b1;
               div_cmd_in.start = 1'b1;
               div_cmd_in.steps = wsdm_pkg::AVERAGE_STEPS;
               div_cmd_in.dividend = sum_sat;
               divisor_in = (cfg.average_limit == '0) ? IW'(1) : IW'(cfg.average_limit);
               state_in = S_AVG_RUN;
            end else begin
               window_in = window_ff + 1'b1;
               sum_in = sum_sat;
               state_in = S_OUT;
            end
         end
         S_AVG_RUN: begin
            if (div_done) begin
               held_in = (|div_quot[SW-1:SPW]) ? '1 : div_quot[SPW-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               res_in.speed_mm_s = held_ff;
               res_in.distance_mm = distance_ff;
               res_in.speed_updated = updated_ff;
               res_in.rev_seen = rev_seen_ff;
               res_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         prev_level_ff <= 1'b1;
         rev_count_ff <= '0;
         last_edge_ff <= '0;
         interval_ff <= IW'(wsdm_pkg::IDLE_INTERVAL);
         idle_ff <= '0;
         window_ff <= '0;
         sum_ff <= '0;
         held_ff <= '0;
         div_cmd_ff.start <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prev_level_ff <= prev_level_in;
         rev_count_ff <= rev_count_in;
         last_edge_ff <= last_edge_in;
         interval_ff <= interval_in;
         idle_ff <= idle_in;
         window_ff <= window_in;
         sum_ff <= sum_in;
         held_ff <= held_in;
         div_cmd_ff.start <= div_cmd_in.start;
         res_valid_ff <= res_valid_in;
      end
      poll_ff <= poll_in;
      rev_seen_ff <= rev_seen_in;
      updated_ff <= updated_in;
      distance_ff <= distance_in;
      div_cmd_ff.steps <= div_cmd_in.steps;
      div_cmd_ff.dividend <= div_cmd_in.dividend;
      divisor_ff <= divisor_in;
      res_ff <= res_in;
   end

   assign poll_ready = state_ff == S_IDLE;
   assign div_cmd = div_cmd_ff;
   assign div_divisor = divisor_ff;
   assign res = res_ff;
   assign res_valid = res_valid_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (poll_valid && poll_ready) |=> !poll_ready)
      else $error("poll taken while a poll is in progress");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_TERM_RUN || state_ff == S_AVG_RUN))
      else $error("divider result outside a run state");

   a_window_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && window_match) |=> (window_ff == LW'(1) && sum_ff == '0))
      else $error("averaging window not restarted");

   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> $past(out_free))
      else $error("result issued while output register full");

endmodule

`default_nettype wire
